// File: sv/oep_pkg.sv
// oep_pkg: shared types and constants for the odd/even partition block.
// No dependencies.
`default_nettype none

package oep_pkg;

   localparam int DEPTH_DEF      = 64;
   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_EVAL,
      ST_SWAP,
      ST_EMIT
   } state_type;

   // source of the RAM write data
   typedef enum logic [1:0] {
      WSEL_REQ,
      WSEL_RIGHT,
      WSEL_LEFT
   } wsel_type;

   typedef struct packed {
      logic     wr_en;
      wsel_type wr_sel;
      logic     rd_en;
      logic     emit;
      logic     emit_last;
   } ctrl_type;

endpackage

`default_nettype wire

// File: sv/odd_even_partition.sv
// odd_even_partition: top level, element RAM, write data select and result registers.
// Depends on oep_pkg, oep_ram, oep_seq.
//
//   channel   ports                                       handshake
//   request   req_data_value, req_is_last                 start && !busy
//   result    rsp_out_value, rsp_out_last, rsp_overflow   rsp_valid, one cycle
//
// Loading takes one cycle per element. After the last element the partition
// walk runs on the shared RAM: each pointer move is a read and a compare, a
// swap adds a write step, and a closing check ends the walk. Emission reads
// one element per cycle and each result shows in the cycle after its read
// (registered RAM read). Reset is synchronous and empties the block. The
// receiver cannot stall.
`default_nettype none

module odd_even_partition #(
   parameter int DEPTH      = oep_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = oep_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [DATA_WIDTH-1:0] req_data_value,
   input  wire logic                         req_is_last,
   output logic                              rsp_valid,
   output logic signed      [DATA_WIDTH-1:0] rsp_out_value,
   output logic                              rsp_out_last,
   output logic                              rsp_overflow
);

   localparam int AW = $clog2(DEPTH);

   oep_pkg::ctrl_type ctrl;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr_a;
   logic [AW-1:0]         rd_addr_b;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data_a;
   logic [DATA_WIDTH-1:0] rd_data_b;
   logic                  overflow;
   logic                  rsp_valid_ff;
   logic                  rsp_last_ff;
   logic                  rsp_ovf_ff;

   oep_seq #(
      .DEPTH(DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_is_last(req_is_last),
      .left_odd   (rd_data_a[0]),
      .right_odd  (rd_data_b[0]),
      .busy       (busy),
      .overflow   (overflow),
      .ctrl       (ctrl),
      .wr_addr    (wr_addr),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b)
   );

   always_comb begin
      case (ctrl.wr_sel)
         oep_pkg::WSEL_REQ:   wr_data = req_data_value;
         oep_pkg::WSEL_RIGHT: wr_data = rd_data_b;
         oep_pkg::WSEL_LEFT:  wr_data = rd_data_a;
         default:             wr_data = req_data_value;
      endcase
   end

   oep_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (ctrl.wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (ctrl.rd_en),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.emit;
      end
      rsp_last_ff <= ctrl.emit_last;
      rsp_ovf_ff  <= overflow;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rd_data_a;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   // the final result leaves the block ready for the next request
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |-> !busy)
      else $error("block still busy after final result");

   // results of one block come out on consecutive cycles
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |=> rsp_valid)
      else $error("gap in result sequence");

   // a result only follows a cycle in which the sequencer was busy
   a_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a running block");

   // no RAM write while results are being read out
   a_emit_no_write: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> !ctrl.wr_en)
      else $error("write during emission");

endmodule

`default_nettype wire

// File: sv/oep_ram.sv
// oep_ram: generic RAM, one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module oep_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// File: sv/oep_seq.sv
// oep_seq: sequencer for load, two-pointer partition walk and emission.
// Depends on oep_pkg.
`default_nettype none

module oep_seq #(
   parameter int DEPTH = oep_pkg::DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     req_is_last,
   input  wire logic                     left_odd,
   input  wire logic                     right_odd,
   output logic                          busy,
   output logic                          overflow,
   output oep_pkg::ctrl_type             ctrl,
   output logic      [$clog2(DEPTH)-1:0] wr_addr,
   output logic      [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [$clog2(DEPTH)-1:0] rd_addr_b
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   oep_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] left_ff, left_in;
   logic [AW-1:0] right_ff, right_in;
   logic [AW-1:0] emit_ff, emit_in;

   logic          accept;
   logic          room;
   logic [CW-1:0] count_next;
   logic [CW-1:0] count_m1;
   logic [CW-1:0] next_m1;
   logic          ptr_lt;
   logic          emit_end;

   assign accept     = start && (state_ff == oep_pkg::ST_LOAD);
   assign room       = count_ff < CW'(DEPTH);
   assign count_next = room ? count_ff + CW'(1) : count_ff;
   assign count_m1   = count_ff - CW'(1);
   assign next_m1    = count_next - CW'(1);
   assign ptr_lt     = left_ff < right_ff;
   assign emit_end   = emit_ff == count_m1[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oep_pkg::ST_LOAD: begin
            if (accept && req_is_last) begin
               state_in = oep_pkg::ST_FETCH;
            end
         end
         oep_pkg::ST_FETCH: begin
            state_in = ptr_lt ? oep_pkg::ST_EVAL : oep_pkg::ST_EMIT;
         end
         oep_pkg::ST_EVAL: begin
            if (left_odd || !right_odd) begin
               state_in = oep_pkg::ST_FETCH;
            end else begin
               state_in = oep_pkg::ST_SWAP;
            end
         end
         oep_pkg::ST_SWAP: begin
            state_in = oep_pkg::ST_FETCH;
         end
         oep_pkg::ST_EMIT: begin
            if (emit_end) begin
               state_in = oep_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = oep_pkg::ST_LOAD;
         end
      endcase
   end

   // outputs to the datapath
   always_comb begin
      ctrl           = '0;
      ctrl.wr_sel    = oep_pkg::WSEL_REQ;
      wr_addr        = count_ff[AW-1:0];
      rd_addr_a      = left_ff;
      rd_addr_b      = right_ff;
      case (state_ff)
         oep_pkg::ST_LOAD: begin
            ctrl.wr_en = accept && room;
         end
         oep_pkg::ST_FETCH: begin
            ctrl.rd_en = ptr_lt;
         end
         oep_pkg::ST_EVAL: begin
            // left even and right odd: left gets the right element first
            ctrl.wr_en  = !left_odd && right_odd;
            ctrl.wr_sel = oep_pkg::WSEL_RIGHT;
            wr_addr     = left_ff;
         end
         oep_pkg::ST_SWAP: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_sel = oep_pkg::WSEL_LEFT;
            wr_addr     = right_ff;
         end
         oep_pkg::ST_EMIT: begin
            ctrl.rd_en     = 1'b1;
            ctrl.emit      = 1'b1;
            ctrl.emit_last = emit_end;
            rd_addr_a      = emit_ff;
         end
         default: begin
            ctrl.wr_en = 1'b0;
         end
      endcase
   end

   // pointers and counters
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      left_in  = left_ff;
      right_in = right_ff;
      emit_in  = emit_ff;
      case (state_ff)
         oep_pkg::ST_LOAD: begin
            if (accept) begin
               count_in = count_next;
               ovf_in   = ovf_ff || !room;
               left_in  = '0;
               right_in = next_m1[AW-1:0];
               emit_in  = '0;
            end
         end
         oep_pkg::ST_EVAL: begin
            if (left_odd) begin
               left_in = left_ff + AW'(1);
            end else if (!right_odd) begin
               right_in = right_ff - AW'(1);
            end
         end
         oep_pkg::ST_EMIT: begin
            emit_in = emit_ff + AW'(1);
            if (emit_end) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            emit_in = emit_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oep_pkg::ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
      left_ff  <= left_in;
      right_ff <= right_in;
      emit_ff  <= emit_in;
   end

   assign busy     = state_ff != oep_pkg::ST_LOAD;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire
